// ----- sv/tga_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA pixel stream decoder package
// Command and status codes, register indexes, queue sizes and the structs
// passed between the front end and the back end.
// ----------------------------------------------------------------------------
package tga_pkg;

  // Input commands
  localparam logic [1:0] CMD_PAL   = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_DATA  = 2'd2;
  localparam logic [1:0] CMD_END   = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_INDEX = 3'd1;
  localparam logic [2:0] ST_OVERRUN   = 3'd2;
  localparam logic [2:0] ST_SHORT     = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_RLE    = 3'd0;
  localparam logic [2:0] REG_PAL    = 3'd1;
  localparam logic [2:0] REG_BPP    = 3'd2;
  localparam logic [2:0] REG_WIDTH  = 3'd3;
  localparam logic [2:0] REG_HEIGHT = 3'd4;
  localparam logic [2:0] REG_PFIRST = 3'd5;
  localparam logic [2:0] REG_PCOUNT = 3'd6;

  // Packet header fields
  localparam logic [7:0] HDR_LEN_MASK = 8'h7F;
  localparam logic [7:0] HDR_RUN_MASK = 8'h80;

  // Command queue between front and back end
  localparam int Q_DEPTH = 4;
  localparam int QAW     = 2;
  localparam int QCW     = QAW + 1;

  // Result queue
  localparam int RES_DEPTH = 4;
  localparam int RAW       = 2;
  localparam int RCW       = RAW + 1;
  localparam int RSW       = RCW + 1;

  typedef struct packed {
    logic        rle;
    logic        pal;
    logic [2:0]  bpp;
    logic [15:0] pal_first;
    logic [15:0] pal_count;
    logic [31:0] total;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  data;
    logic [7:0]  offs;
    logic [31:0] color;
    logic        wr_ok;
    logic        idx_bad;
    logic [7:0]  pal_off;
  } item_t;

  typedef struct packed {
    logic [31:0] value;
    logic [7:0]  count;
    logic [2:0]  status;
    logic        last;
  } res_t;

endpackage

// ----- sv/tga_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA decoder front end
// Accepts input transactions, precomputes palette index checks and queues
// the classified items for the back end.
// ----------------------------------------------------------------------------
module tga_front import tga_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  entry_offset,
  input  logic [31:0] entry_color,
  output logic        q_valid,
  output item_t       q_head,
  input  logic        q_pop
);

  localparam logic [QCW-1:0] Q_FULL = QCW'(Q_DEPTH);

  item_t          q_mem [Q_DEPTH];
  logic [QAW-1:0] q_wptr;
  logic [QAW-1:0] q_rptr;
  logic [QCW-1:0] q_count;
  item_t          item;
  logic [15:0]    off_wide;
  logic           do_push;
  logic           do_pop;

  // Palette offset of the data byte; only meaningful when not flagged bad
  assign off_wide = {8'd0, data_byte} - cfg.pal_first;

  always_comb begin
    item.cmd     = cmd;
    item.data    = data_byte;
    item.offs    = entry_offset;
    item.color   = entry_color;
    item.wr_ok   = ({1'b0, entry_offset} < 9'(PALETTE_DEPTH));
    item.idx_bad = ({8'd0, data_byte} < cfg.pal_first) ||
                   (off_wide >= cfg.pal_count) ||
                   (off_wide >= 16'(PALETTE_DEPTH));
    item.pal_off = off_wide[7:0];
  end

  assign full    = (q_count == Q_FULL);
  assign q_valid = (q_count != '0);
  assign q_head  = q_mem[q_rptr];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[q_wptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wptr  <= '0;
      q_rptr  <= '0;
      q_count <= '0;
    end else begin
      if (do_push) begin
        q_wptr <= q_wptr + 1'b1;
      end
      if (do_pop) begin
        q_rptr <= q_rptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   q_count <= q_count + 1'b1;
        2'b01:   q_count <= q_count - 1'b1;
        default: q_count <= q_count;
      endcase
    end
  end

  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= Q_FULL)
    else $error("command queue count beyond depth");

  a_q_track: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (q_count == $past(q_count) + 1'b1))
    else $error("command queue count lost a push");

endmodule

// ----- sv/tga_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA decoder back end
// Runs the frame and packet state, assembles pixels, looks up the palette
// and queues results for the receiver.
// ----------------------------------------------------------------------------
module tga_back import tga_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  q_valid,
  input  item_t q_head,
  output logic  q_pop,
  output logic  empty,
  input  logic  pop,
  output res_t  res
);

  localparam int PAW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam logic [RSW-1:0] RES_LIMIT = RSW'(RES_DEPTH);
  localparam logic [RCW-1:0] RES_FULL  = RCW'(RES_DEPTH);

  // Frame and packet state
  logic [7:0]  pk_left;
  logic        run_pkt;
  logic        expect_hdr;
  logic [23:0] gather;
  logic [1:0]  slot;
  logic [31:0] pix_done;
  logic        halted;

  logic [7:0]  pk_left_next;
  logic        run_next;
  logic        expect_hdr_next;
  logic [23:0] gather_next;
  logic [1:0]  slot_next;
  logic [31:0] pix_done_next;
  logic        halted_next;

  // Palette memory
  logic [31:0] pal_mem [PALETTE_DEPTH];
  logic [31:0] mem_q;

  // Execute stage outputs
  logic        a_go;
  logic        a_res;
  logic [2:0]  a_status;
  logic [7:0]  a_count;
  logic        a_last;
  logic        a_use_mem;
  logic [31:0] a_val;
  logic [2:0]  eff_bpp;
  logic [31:0] mask;
  logic [31:0] shifted;
  logic [31:0] merged;
  logic        slot_last;
  logic        done_full;
  logic        over;
  logic        ready;
  logic [7:0]  cnt;
  logic [31:0] done_sum;
  logic [7:0]  hdr_len;

  // Result stage
  logic        b_valid;
  logic [2:0]  b_status;
  logic [7:0]  b_count;
  logic        b_last;
  logic        b_use_mem;
  logic [31:0] b_val;
  logic [31:0] b_mask;
  res_t        b_res;

  // Result queue
  res_t           res_mem [RES_DEPTH];
  logic [RAW-1:0] res_wptr;
  logic [RAW-1:0] res_rptr;
  logic [RCW-1:0] res_count;
  logic           res_pop;

  // Take an item only when the result queue has room for it and the one ahead
  assign a_go  = q_valid && ((RSW'(res_count) + RSW'(b_valid)) < RES_LIMIT);
  assign q_pop = a_go;

  always_comb begin
    if (cfg.bpp == 3'd0) begin
      eff_bpp = 3'd1;
    end else if (cfg.bpp > 3'd4) begin
      eff_bpp = 3'd4;
    end else begin
      eff_bpp = cfg.bpp;
    end
    case (eff_bpp)
      3'd1:    mask = 32'h0000_00FF;
      3'd2:    mask = 32'h0000_FFFF;
      3'd3:    mask = 32'h00FF_FFFF;
      default: mask = 32'hFFFF_FFFF;
    endcase
  end

  assign shifted   = {24'd0, q_head.data} << {slot, 3'b000};
  assign merged    = {8'd0, gather} | shifted;
  assign slot_last = (({1'b0, slot} + 3'd1) >= eff_bpp);
  assign done_full = (pix_done >= cfg.total);
  assign hdr_len   = (q_head.data & HDR_LEN_MASK) + 8'd1;
  assign over      = (({1'b0, pix_done} + {25'd0, hdr_len}) > {1'b0, cfg.total});

  always_comb begin
    pk_left_next    = pk_left;
    run_next        = run_pkt;
    expect_hdr_next = expect_hdr;
    gather_next     = gather;
    slot_next       = slot;
    pix_done_next   = pix_done;
    halted_next     = halted;
    a_res           = 1'b0;
    a_status        = ST_OK;
    a_count         = 8'd0;
    a_last          = 1'b0;
    a_use_mem       = 1'b0;
    a_val           = 32'd0;
    ready           = 1'b0;
    cnt             = 8'd0;
    done_sum        = pix_done;
    if (a_go) begin
      case (q_head.cmd)
        CMD_PAL: begin
        end
        CMD_START: begin
          pk_left_next    = 8'd0;
          run_next        = 1'b0;
          expect_hdr_next = 1'b1;
          gather_next     = 24'd0;
          slot_next       = 2'd0;
          pix_done_next   = 32'd0;
          halted_next     = (cfg.total == 32'd0);
          if (cfg.total == 32'd0) begin
            a_res    = 1'b1;
            a_status = ST_EMPTY;
          end
        end
        CMD_END: begin
          if (!halted) begin
            halted_next = 1'b1;
            a_res       = 1'b1;
            a_status    = ST_SHORT;
          end
        end
        default: begin
          if (!halted) begin
            if (done_full) begin
              // Size shrank under a running frame: stop quietly
              halted_next = 1'b1;
            end else if (cfg.rle && expect_hdr) begin
              if (over) begin
                halted_next = 1'b1;
                a_res       = 1'b1;
                a_status    = ST_OVERRUN;
              end else begin
                pk_left_next    = hdr_len;
                run_next        = ((q_head.data & HDR_RUN_MASK) != 8'd0);
                expect_hdr_next = 1'b0;
                gather_next     = 24'd0;
                slot_next       = 2'd0;
              end
            end else if (cfg.pal) begin
              if (q_head.idx_bad) begin
                halted_next = 1'b1;
                a_res       = 1'b1;
                a_status    = ST_BAD_INDEX;
              end else begin
                ready     = 1'b1;
                a_use_mem = 1'b1;
              end
            end else if (slot_last) begin
              ready       = 1'b1;
              a_val       = merged & mask;
              gather_next = 24'd0;
              slot_next   = 2'd0;
            end else begin
              gather_next = merged[23:0];
              slot_next   = slot + 2'd1;
            end
          end
        end
      endcase
      if (ready) begin
        if (!cfg.rle) begin
          cnt = 8'd1;
        end else if (run_pkt) begin
          cnt             = pk_left;
          pk_left_next    = 8'd0;
          expect_hdr_next = 1'b1;
        end else begin
          cnt          = 8'd1;
          pk_left_next = pk_left - 8'd1;
          if (pk_left == 8'd1) begin
            expect_hdr_next = 1'b1;
          end
        end
        done_sum      = pix_done + {24'd0, cnt};
        pix_done_next = done_sum;
        a_res         = 1'b1;
        a_count       = cnt;
        a_last        = (done_sum >= cfg.total);
        if (done_sum >= cfg.total) begin
          halted_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pk_left    <= 8'd0;
      run_pkt    <= 1'b0;
      expect_hdr <= 1'b1;
      gather     <= 24'd0;
      slot       <= 2'd0;
      pix_done   <= 32'd0;
      halted     <= 1'b1;
    end else begin
      pk_left    <= pk_left_next;
      run_pkt    <= run_next;
      expect_hdr <= expect_hdr_next;
      gather     <= gather_next;
      slot       <= slot_next;
      pix_done   <= pix_done_next;
      halted     <= halted_next;
    end
  end

  // Palette write and registered lookup for the item at the head
  always_ff @(posedge clk) begin
    if (a_go && (q_head.cmd == CMD_PAL) && q_head.wr_ok) begin
      pal_mem[q_head.offs[PAW-1:0]] <= q_head.color;
    end
    mem_q <= pal_mem[q_head.pal_off[PAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_go && a_res;
    end
  end

  always_ff @(posedge clk) begin
    b_status  <= a_status;
    b_count   <= a_count;
    b_last    <= a_last;
    b_use_mem <= a_use_mem;
    b_val     <= a_val;
    b_mask    <= mask;
  end

  always_comb begin
    b_res.value  = b_use_mem ? (mem_q & b_mask) : b_val;
    b_res.count  = b_count;
    b_res.status = b_status;
    b_res.last   = b_last;
  end

  assign empty   = (res_count == '0);
  assign res     = res_mem[res_rptr];
  assign res_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (b_valid) begin
      res_mem[res_wptr] <= b_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wptr  <= '0;
      res_rptr  <= '0;
      res_count <= '0;
    end else begin
      if (b_valid) begin
        res_wptr <= res_wptr + 1'b1;
      end
      if (res_pop) begin
        res_rptr <= res_rptr + 1'b1;
      end
      case ({b_valid, res_pop})
        2'b10:   res_count <= res_count + 1'b1;
        2'b01:   res_count <= res_count - 1'b1;
        default: res_count <= res_count;
      endcase
    end
  end

  a_res_bound: assert property (@(posedge clk) disable iff (rst)
    res_count <= RES_FULL)
    else $error("result queue overflow");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (b_valid && (b_status != ST_OK)) |-> ((b_count == 8'd0) && !b_last && !b_use_mem &&
                                          (b_val == 32'd0)))
    else $error("error result carries pixel data");

  a_ok_count: assert property (@(posedge clk) disable iff (rst)
    (b_valid && (b_status == ST_OK)) |-> (b_count != 8'd0))
    else $error("pixel result with zero repeat count");

  a_last_halts: assert property (@(posedge clk) disable iff (rst)
    (a_go && a_res && a_last) |=> halted)
    else $error("frame still running after its last pixel");

endmodule

// ----- sv/tga_pixel_stream_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA pixel stream decoder
// Decodes raw or run-length TGA pixel data, palette or direct color.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive cmd and its fields with push; a transaction
//   is taken when push is high and full is low. Commands load palette
//   entries, start a frame, feed one data byte or mark the end of data.
//   Result side is a queue: while empty is low the oldest result sits on
//   pixel_value, repeat_count, status and last_pixel; pop takes it.
//   Configuration goes through cfg_we / cfg_index / cfg_data while the block
//   is idle; registers follow the index order rle, palette mode, bytes per
//   pixel, width, height, palette first, palette count.
//   Throughput is one transaction per cycle while full is low. After its
//   transaction is taken, a result passes the command queue, the execute
//   stage (state update and palette read) and then the result stage.
//   Reset clears the queues and leaves the frame halted; palette contents
//   are undefined until written.
//   When pop stays low the four-entry result queue fills, the back end stops
//   and the four-entry command queue then raises full.
// ----------------------------------------------------------------------------
module tga_pixel_stream_decoder import tga_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  entry_offset,
  input  logic [31:0] entry_color,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] pixel_value,
  output logic [7:0]  repeat_count,
  output logic [2:0]  status,
  output logic        last_pixel,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic        rle_mode;
  logic        palette_mode;
  logic [2:0]  bytes_per_pixel;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [15:0] palette_first;
  logic [15:0] palette_count;
  logic [31:0] total;

  cfg_t  cfg;
  item_t q_head;
  logic  q_valid;
  logic  q_pop;
  res_t  res;

  always_ff @(posedge clk) begin
    if (rst) begin
      rle_mode        <= 1'b0;
      palette_mode    <= 1'b0;
      bytes_per_pixel <= 3'd3;
      image_width     <= 16'd0;
      image_height    <= 16'd0;
      palette_first   <= 16'd0;
      palette_count   <= 16'd0;
      total           <= 32'd0;
    end else begin
      // Pixel count of the image, registered from the width and height registers
      total <= {16'd0, image_width} * {16'd0, image_height};
      if (cfg_we) begin
        case (cfg_index)
          REG_RLE:    rle_mode        <= cfg_data[0];
          REG_PAL:    palette_mode    <= cfg_data[0];
          REG_BPP:    bytes_per_pixel <= cfg_data[2:0];
          REG_WIDTH:  image_width     <= cfg_data;
          REG_HEIGHT: image_height    <= cfg_data;
          REG_PFIRST: palette_first   <= cfg_data;
          REG_PCOUNT: palette_count   <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    cfg.rle       = rle_mode;
    cfg.pal       = palette_mode;
    cfg.bpp       = bytes_per_pixel;
    cfg.pal_first = palette_first;
    cfg.pal_count = palette_count;
    cfg.total     = total;
  end

  tga_front #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .push         (push),
    .full         (full),
    .cmd          (cmd),
    .data_byte    (data_byte),
    .entry_offset (entry_offset),
    .entry_color  (entry_color),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop)
  );

  tga_back #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .res     (res)
  );

  assign pixel_value  = res.value;
  assign repeat_count = res.count;
  assign status       = res.status;
  assign last_pixel   = res.last;

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA pixel stream decoder testbench
// Loads the palette, runs short directed frames and then random frames in raw
// and run-length form, palette and direct color, plus command noise. Both
// queue sides idle in random bursts. A scoreboard decodes every accepted
// transaction and checks each popped result field by field, in order.
// ----------------------------------------------------------------------------
module tb;
  import tga_pkg::*;

  localparam int PAL_SLOTS   = 256;
  localparam int ITEM_GOAL   = 900;
  localparam int CALM_AFTER  = 800;
  localparam int SETTLE      = 10;
  localparam int WATCH_LIMIT = 2000;

  class pixel_scoreboard;
    bit [31:0] pal_mem [PAL_SLOTS];
    bit        rle, pal;
    bit [2:0]  bpp;
    bit [15:0] width, height, pfirst, pcount;
    bit [7:0]  pkt_left;
    bit        run_pkt, want_hdr;
    bit [23:0] gather;
    bit [1:0]  slot;
    bit [31:0] done;
    bit        halted;
    res_t      expected_pixels[$];
    int        mismatches;

    function new();
      want_hdr = 1'b1;
      halted   = 1'b1;
      bpp      = 3'd3;
    endfunction

    function void set_reg(bit [2:0] idx, bit [15:0] v);
      case (idx)
        REG_RLE:    rle = v[0];
        REG_PAL:    pal = v[0];
        REG_BPP:    bpp = v[2:0];
        REG_WIDTH:  width = v;
        REG_HEIGHT: height = v;
        REG_PFIRST: pfirst = v;
        REG_PCOUNT: pcount = v;
        default: ;
      endcase
    endfunction

    function int pixel_bytes();
      if (bpp == 0) return 1;
      if (bpp > 4) return 4;
      return int'(bpp);
    endfunction

    function bit [31:0] keep_mask();
      int n;
      n = pixel_bytes();
      return (n >= 4) ? 32'hFFFF_FFFF : (32'h1 << (8 * n)) - 32'h1;
    endfunction

    function void add_result(bit [31:0] value, bit [7:0] count, bit [2:0] st, bit last);
      res_t r;
      r.value  = value;
      r.count  = count;
      r.status = st;
      r.last   = last;
      expected_pixels.push_back(r);
    endfunction

    function void halt_with(bit [2:0] st);
      halted = 1'b1;
      add_result(32'h0, 8'h0, st, 1'b0);
    endfunction

    function void finish_pixel(bit [31:0] value, bit [7:0] count, bit [63:0] total);
      bit last;
      done = done + 32'(count);
      last = ({32'h0, done} >= total);
      if (last) halted = 1'b1;
      add_result(value, count, ST_OK, last);
    endfunction

    // 1: pixel ready, 0: more bytes needed, -1: bad palette index
    function int gather_byte(bit [7:0] b, output bit [31:0] value);
      bit [31:0] off, merged;
      value = 32'h0;
      if (pal) begin
        if (16'(b) < pfirst) return -1;
        off = 32'(b) - 32'(pfirst);
        if (off >= 32'(pcount) || off >= PAL_SLOTS) return -1;
        value = pal_mem[off[7:0]] & keep_mask();
        return 1;
      end
      merged = {8'h0, gather} | (32'(b) << (8 * slot));
      if (slot + 1 >= pixel_bytes()) begin
        value  = merged & keep_mask();
        gather = '0;
        slot   = '0;
        return 1;
      end
      gather = merged[23:0];
      slot   = slot + 2'd1;
      return 0;
    endfunction

    function void note_item(bit [1:0] c, bit [7:0] b, bit [7:0] offs, bit [31:0] color);
      bit [63:0] total;
      bit [31:0] value;
      bit [7:0]  n;
      int        got;
      total = 64'(width) * 64'(height);
      case (c)
        CMD_PAL: pal_mem[offs] = color;
        CMD_START: begin
          pkt_left = '0;
          run_pkt  = 1'b0;
          want_hdr = 1'b1;
          gather   = '0;
          slot     = '0;
          done     = '0;
          halted   = 1'b0;
          if (total == 0) halt_with(ST_EMPTY);
        end
        CMD_END: if (!halted) halt_with(ST_SHORT);
        CMD_DATA: begin
          if (halted) return;
          // size shrank under a running frame: stop without a result
          if ({32'h0, done} >= total) begin
            halted = 1'b1;
            return;
          end
          if (rle && want_hdr) begin
            n = (b & HDR_LEN_MASK) + 8'd1;
            if ({32'h0, done} + 64'(n) > total) begin
              halt_with(ST_OVERRUN);
              return;
            end
            pkt_left = n;
            run_pkt  = ((b & HDR_RUN_MASK) != 0);
            want_hdr = 1'b0;
            gather   = '0;
            slot     = '0;
            return;
          end
          got = gather_byte(b, value);
          if (got < 0) begin
            halt_with(ST_BAD_INDEX);
          end else if (got > 0) begin
            if (!rle) begin
              finish_pixel(value, 8'd1, total);
            end else if (run_pkt) begin
              n        = pkt_left;
              pkt_left = '0;
              want_hdr = 1'b1;
              finish_pixel(value, n, total);
            end else begin
              pkt_left = pkt_left - 8'd1;
              if (pkt_left == 0) want_hdr = 1'b1;
              finish_pixel(value, 8'd1, total);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void complain(string msg);
      if (mismatches < 10) $display("%0t: %s", $time, msg);
      mismatches++;
    endfunction

    function void check_pixel(res_t got);
      res_t want;
      if (expected_pixels.size() == 0) begin
        complain($sformatf("unexpected result: value %h count %0d status %0d last %0d",
                           got.value, got.count, got.status, got.last));
        return;
      end
      want = expected_pixels.pop_front();
      if (got !== want)
        complain($sformatf({"result mismatch: expected value %h count %0d status %0d ",
                            "last %0d, got value %h count %0d status %0d last %0d"},
                           want.value, want.count, want.status, want.last,
                           got.value, got.count, got.status, got.last));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  cmd = CMD_PAL;
  logic [7:0]  data_byte = '0;
  logic [7:0]  entry_offset = '0;
  logic [31:0] entry_color = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] pixel_value;
  logic [7:0]  repeat_count;
  logic [2:0]  status;
  logic        last_pixel;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_RLE;
  logic [15:0] cfg_data = '0;

  pixel_scoreboard sb;
  int sent   = 0;
  int quiet  = 0;
  bit bursty = 1'b1;
  bit calm   = 1'b0;

  tga_pixel_stream_decoder uut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .cmd          (cmd),
    .data_byte    (data_byte),
    .entry_offset (entry_offset),
    .entry_color  (entry_color),
    .empty        (empty),
    .pop          (pop),
    .pixel_value  (pixel_value),
    .repeat_count (repeat_count),
    .status       (status),
    .last_pixel   (last_pixel),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send(bit [1:0] c, bit [7:0] b, bit [7:0] o, bit [31:0] col);
    if (!calm && bursty && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    push         <= 1'b1;
    cmd          <= c;
    data_byte    <= b;
    entry_offset <= o;
    entry_color  <= col;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_item(c, b, o, col);
    sent++;
  endtask

  task automatic send_byte(bit [7:0] b);
    send(CMD_DATA, b, 8'($urandom), $urandom);
  endtask

  // Drain all expected results, then let queued no-result commands retire.
  task automatic settle();
    push <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(bit r, bit p, bit [2:0] bp, bit [15:0] w, bit [15:0] h,
                           bit [15:0] pf, bit [15:0] pc);
    bit [2:0]  regs [7];
    bit [15:0] vals [7];
    regs = '{REG_RLE, REG_PAL, REG_BPP, REG_WIDTH, REG_HEIGHT, REG_PFIRST, REG_PCOUNT};
    vals = '{16'(r), 16'(p), 16'(bp), w, h, pf, pc};
    settle();
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.set_reg(regs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Result side: check on every pop transaction, stall in random bursts.
  initial begin : pop_side
    int   stall;
    res_t seen;
    stall = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        seen.value  = pixel_value;
        seen.count  = repeat_count;
        seen.status = status;
        seen.last   = last_pixel;
        sb.check_pixel(seen);
      end
      if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else if (!calm && bursty && $urandom_range(0, 9) == 0) begin
        stall = int'($urandom_range(1, 13)) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || cfg_we) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCH_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    bit        r, p, run;
    bit [2:0]  bp;
    bit [15:0] w, h, pf, pc;
    bit [7:0]  idx;
    bit [63:0] total;
    int        target, left, n, lim, pb;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Halted after reset: end of data and data bytes do nothing; zero size is empty.
    send(CMD_END, 8'h00, 8'h00, 32'h0);
    send_byte(8'hFF);
    send(CMD_START, 8'h00, 8'h00, 32'h0);
    send(CMD_PAL, 8'h00, 8'd0, 32'hFFFF_FFFF);
    send(CMD_PAL, 8'hFF, 8'd1, 32'h0000_0000);
    send(CMD_PAL, 8'h00, 8'd2, 32'hA5C3_3C5A);
    send(CMD_PAL, 8'h00, 8'd3, 32'h1234_5678);
    // Palette lookups, then an index below the first and one past the count.
    configure(1'b0, 1'b1, 3'd4, 16'd2, 16'd2, 16'd10, 16'd4);
    send(CMD_START, 8'h00, 8'h00, 32'h0);
    send_byte(8'd10);
    send_byte(8'd13);
    send_byte(8'd9);
    send(CMD_START, 8'h00, 8'h00, 32'h0);
    send_byte(8'd14);
    // Run packet too long for the image, then one that exactly fills it.
    configure(1'b1, 1'b0, 3'd3, 16'd3, 16'd1, 16'd0, 16'd0);
    send(CMD_START, 8'h00, 8'h00, 32'h0);
    send_byte(8'hFF);
    send(CMD_START, 8'h00, 8'h00, 32'h0);
    send_byte(8'h82);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h55);
    send(CMD_END, 8'h00, 8'h00, 32'h0);
    // Largest image: longest run, then end of data while still running.
    configure(1'b1, 1'b0, 3'd1, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
    send(CMD_START, 8'h00, 8'h00, 32'h0);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send(CMD_END, 8'h00, 8'h00, 32'h0);

    // Fill every palette slot so later index reads only hit written entries.
    for (int i = 0; i < PAL_SLOTS; i++) send(CMD_PAL, 8'($urandom), i[7:0], $urandom);

    while (sent < ITEM_GOAL) begin
      calm   = (sent >= CALM_AFTER);
      bursty = ($urandom_range(0, 3) != 0);
      r = 1'($urandom_range(0, 1));
      p = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 3) == 0) bp = 3'($urandom_range(0, 7));
      else bp = ($urandom_range(0, 1) == 0) ? 3'd3 : (($urandom_range(0, 1) == 0) ? 3'd4 : 3'd1);
      case ($urandom_range(0, 15))
        0: begin w = 16'd0; h = 16'($urandom); end
        1: begin w = 16'($urandom); h = 16'd0; end
        2: begin w = 16'hFFFF; h = 16'hFFFF; end
        3: begin w = 16'($urandom); h = 16'($urandom_range(1, 3)); end
        default: begin w = 16'($urandom_range(1, 8)); h = 16'($urandom_range(1, 4)); end
      endcase
      case ($urandom_range(0, 7))
        0: begin pf = 16'($urandom); pc = 16'($urandom); end
        1: begin pf = 16'hFFFF; pc = 16'hFFFF; end
        2: begin pf = 16'd0; pc = 16'd0; end
        default: begin
          pf = 16'($urandom_range(0, 200));
          pc = 16'($urandom_range(1, 256 - int'(pf)));
        end
      endcase
      configure(r, p, bp, w, h, pf, pc);

      lim = 0;
      if (pf <= 255) begin
        lim = 256 - int'(pf);
        if (int'(pc) < lim) lim = int'(pc);
      end
      pb = (bp == 0) ? 1 : ((bp > 4) ? 4 : int'(bp));

      if ($urandom_range(0, 4) == 0) begin
        // noise: any command with any fields
        repeat ($urandom_range(4, 20))
          send(2'($urandom), 8'($urandom), 8'($urandom), $urandom);
      end else begin
        // now and then keep decoding the old frame under the new setting
        if ($urandom_range(0, 9) != 0)
          send(CMD_START, 8'($urandom), 8'($urandom), $urandom);
        total  = 64'(w) * 64'(h);
        target = $urandom_range(1, 40);
        if (total < 64'(target)) target = int'(total);
        left = target;
        while (left > 0) begin
          n   = 1;
          run = 1'b1;
          if (r) begin
            n = $urandom_range(1, (left < 128) ? left : 128);
            if ($urandom_range(0, 15) == 0) n = $urandom_range(1, 128);
            run = 1'($urandom_range(0, 1));
            send_byte({run, 7'(n - 1)});
          end
          repeat (run ? 1 : n) begin
            if (p) begin
              if (lim > 0 && $urandom_range(0, 11) != 0)
                idx = 8'(int'(pf) + $urandom_range(0, lim - 1));
              else idx = 8'($urandom);
              send_byte(idx);
            end else begin
              repeat (pb) send_byte(8'($urandom));
            end
          end
          if ($urandom_range(0, 29) == 0)
            send(CMD_PAL, 8'($urandom), 8'($urandom), $urandom);
          left = (n >= left) ? 0 : left - n;
        end
        if ($urandom_range(0, 2) == 0) send_byte(8'($urandom));
        if ($urandom_range(0, 1) == 0)
          send(CMD_END, 8'($urandom), 8'($urandom), $urandom);
      end
    end

    push <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (2 * SETTLE) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
